// File: src/imf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package imf_pkg;

	localparam int NODES   = 64;
	localparam int NODE_W  = 6;
	localparam int ADDR_W  = 2 * NODE_W;
	localparam int CELLS   = NODES * NODES;
	localparam int CAP_W   = 8;
	localparam int VAL_W   = 14;
	localparam int PTR_W   = NODE_W + 1;
	localparam int ACT_W   = 5;

	localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);
	localparam logic [CAP_W-1:0]  LIMIT_RST = CAP_W'(100);

	localparam logic [1:0] OP_SET    = 2'd0;
	localparam logic [1:0] OP_SOLVE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_TOTAL = 2'd1;
	localparam logic [1:0] KIND_FLOW  = 2'd2;

	localparam logic [1:0] REG_SOURCE = 2'd0;
	localparam logic [1:0] REG_SINK   = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;

	localparam logic [ACT_W-1:0] A_NONE    = 5'd0;
	localparam logic [ACT_W-1:0] A_CLR     = 5'd1;
	localparam logic [ACT_W-1:0] A_ACCEPT  = 5'd2;
	localparam logic [ACT_W-1:0] A_SET     = 5'd3;
	localparam logic [ACT_W-1:0] A_RDREQ   = 5'd4;
	localparam logic [ACT_W-1:0] A_RD_W    = 5'd5;
	localparam logic [ACT_W-1:0] A_NULL    = 5'd6;
	localparam logic [ACT_W-1:0] A_INIT    = 5'd7;
	localparam logic [ACT_W-1:0] A_DEQ_RD  = 5'd8;
	localparam logic [ACT_W-1:0] A_DEQ_W   = 5'd9;
	localparam logic [ACT_W-1:0] A_LAB_W   = 5'd10;
	localparam logic [ACT_W-1:0] A_SCAN_RD = 5'd11;
	localparam logic [ACT_W-1:0] A_SCAN_EV = 5'd12;
	localparam logic [ACT_W-1:0] A_AUG_ST  = 5'd13;
	localparam logic [ACT_W-1:0] A_AUG_RD  = 5'd14;
	localparam logic [ACT_W-1:0] A_AUG_PW  = 5'd15;
	localparam logic [ACT_W-1:0] A_AUG_FW  = 5'd16;
	localparam logic [ACT_W-1:0] A_SUM_ST  = 5'd17;
	localparam logic [ACT_W-1:0] A_SUM_RD  = 5'd18;
	localparam logic [ACT_W-1:0] A_SUM_EV  = 5'd19;
	localparam logic [ACT_W-1:0] A_PUSH    = 5'd20;

	typedef struct packed {
		logic [ACT_W-1:0] act;
	} cmd_t;

	typedef struct packed {
		logic       in_fire;
		logic [1:0] in_op;
		logic       src_eq_snk;
		logic       q_nonempty;
		logic       v_last;
		logic       sink_hit;
		logic       cur_is_src;
		logic       clr_last;
		logic       out_free;
	} sts_t;

endpackage

// File: src/incremental_max_flow_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_max_flow_engine_unit
// Incremental Edmonds-Karp max-flow engine over a 64-node adjacency matrix.
// ----------------------------------------------------------------------------
// After reset the engine clears the capacity and flow stores (one matrix
// cell per cycle) and accepts no input transaction in that time;
// configuration writes are taken at any time. A set or read transaction
// passes through its own states and ends with one result. A solve runs
// breadth-first searches in which each dequeued node scans the 64 candidate
// nodes in turn, each read and then evaluated, bounded by the single read
// port of the arc stores, until the sink is reached; each path arc is then
// walked back from the sink, and a final pass sums the flow out of the
// source. The total depends on the number of augmenting paths found. A
// finished result sits in an output register until it is taken, and the
// next input transaction is accepted once the result has moved there.
// Input tuser carries the operation code; the output tuser carries the kind.
module incremental_max_flow_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata from bit 0: from_node[5:0], to_node[11:6], capacity[19:12], zero pad
	input  logic [23:0] s_axis_tdata,
	// tuser: operation[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata from bit 0: value[13:0], zero pad
	output logic [15:0] m_axis_tdata,
	// tuser: kind[1:0]
	output logic [1:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	imf_pkg::cmd_t cmd;
	imf_pkg::sts_t sts;

	// The controller sequences every transaction; the datapath owns all state.
	imf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	imf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

endmodule

// File: src/imf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module imf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/imf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_ctrl
// Sequencer for clearing, set/read transactions and the max-flow search.
// ----------------------------------------------------------------------------
module imf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  imf_pkg::sts_t  sts,
	output imf_pkg::cmd_t  cmd
);

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_SET    = 5'd2;
	localparam logic [4:0] S_RD     = 5'd3;
	localparam logic [4:0] S_RDW    = 5'd4;
	localparam logic [4:0] S_NULL   = 5'd5;
	localparam logic [4:0] S_INIT   = 5'd6;
	localparam logic [4:0] S_DEQ    = 5'd7;
	localparam logic [4:0] S_DEQW   = 5'd8;
	localparam logic [4:0] S_LABW   = 5'd9;
	localparam logic [4:0] S_SRD    = 5'd10;
	localparam logic [4:0] S_SEV    = 5'd11;
	localparam logic [4:0] S_AUG_ST = 5'd12;
	localparam logic [4:0] S_AP     = 5'd13;
	localparam logic [4:0] S_APW    = 5'd14;
	localparam logic [4:0] S_AFW    = 5'd15;
	localparam logic [4:0] S_SUM_ST = 5'd16;
	localparam logic [4:0] S_SUMRD  = 5'd17;
	localparam logic [4:0] S_SUMEV  = 5'd18;
	localparam logic [4:0] S_PUSH   = 5'd19;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.act = imf_pkg::A_NONE;
		unique case (state_q)
			S_CLR: begin
				cmd.act = imf_pkg::A_CLR;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.act = imf_pkg::A_ACCEPT;
				if (sts.in_fire) begin
					priority case (sts.in_op)
						imf_pkg::OP_SET:   state_d = S_SET;
						imf_pkg::OP_READ:  state_d = S_RD;
						imf_pkg::OP_SOLVE: state_d = sts.src_eq_snk ? S_SUM_ST : S_INIT;
						default:           state_d = S_NULL;
					endcase
				end
			end
			S_SET: begin
				cmd.act = imf_pkg::A_SET;
				state_d = S_PUSH;
			end
			S_RD: begin
				cmd.act = imf_pkg::A_RDREQ;
				state_d = S_RDW;
			end
			S_RDW: begin
				cmd.act = imf_pkg::A_RD_W;
				state_d = S_PUSH;
			end
			S_NULL: begin
				cmd.act = imf_pkg::A_NULL;
				state_d = S_PUSH;
			end
			S_INIT: begin
				cmd.act = imf_pkg::A_INIT;
				state_d = S_DEQ;
			end
			S_DEQ: begin
				cmd.act = imf_pkg::A_DEQ_RD;
				state_d = sts.q_nonempty ? S_DEQW : S_SUM_ST;
			end
			S_DEQW: begin
				cmd.act = imf_pkg::A_DEQ_W;
				state_d = S_LABW;
			end
			S_LABW: begin
				cmd.act = imf_pkg::A_LAB_W;
				state_d = S_SRD;
			end
			S_SRD: begin
				cmd.act = imf_pkg::A_SCAN_RD;
				state_d = S_SEV;
			end
			S_SEV: begin
				cmd.act = imf_pkg::A_SCAN_EV;
				if (sts.sink_hit) state_d = S_AUG_ST;
				else if (sts.v_last) state_d = S_DEQ;
				else state_d = S_SRD;
			end
			S_AUG_ST: begin
				cmd.act = imf_pkg::A_AUG_ST;
				state_d = S_AP;
			end
			S_AP: begin
				cmd.act = imf_pkg::A_AUG_RD;
				state_d = sts.cur_is_src ? S_INIT : S_APW;
			end
			S_APW: begin
				cmd.act = imf_pkg::A_AUG_PW;
				state_d = S_AFW;
			end
			S_AFW: begin
				cmd.act = imf_pkg::A_AUG_FW;
				state_d = S_AP;
			end
			S_SUM_ST: begin
				cmd.act = imf_pkg::A_SUM_ST;
				state_d = S_SUMRD;
			end
			S_SUMRD: begin
				cmd.act = imf_pkg::A_SUM_RD;
				state_d = S_SUMEV;
			end
			S_SUMEV: begin
				cmd.act = imf_pkg::A_SUM_EV;
				if (sts.v_last) state_d = S_PUSH;
				else state_d = S_SUMRD;
			end
			S_PUSH: begin
				cmd.act = imf_pkg::A_PUSH;
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLR;
			end
		endcase
	end

endmodule

// File: src/imf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_dp
// Datapath: arc stores, search queue, labels, parents, counters, ports.
// ----------------------------------------------------------------------------
module imf_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  imf_pkg::cmd_t              cmd,
	output imf_pkg::sts_t              sts,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [23:0]                s_axis_tdata,
	input  logic [1:0]                 s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [15:0]                m_axis_tdata,
	output logic [1:0]                 m_axis_tuser,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [7:0]                 cfg_data
);

	localparam int NW = imf_pkg::NODE_W;
	localparam int AW = imf_pkg::ADDR_W;
	localparam int CW = imf_pkg::CAP_W;
	localparam int VW = imf_pkg::VAL_W;
	localparam int PW = imf_pkg::PTR_W;

	logic [NW-1:0] src_q, snk_q;
	logic [CW-1:0] limit_q;
	logic [NW-1:0] from_q, to_q;
	logic [CW-1:0] capin_q;
	logic [AW-1:0] clr_cnt_q;
	logic [PW-1:0] head_q, tail_q;
	logic [NW-1:0] u_q, v_q, cur_q, pu_q;
	logic [CW-1:0] lab_u_q, d_q;
	logic          rev_q;
	logic [AW-1:0] aug_addr_q;
	logic [imf_pkg::NODES-1:0] visited_q;
	logic [1:0]    res_kind_q;
	logic [VW-1:0] res_val_q;
	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [VW-1:0] out_val_q;

	logic act_clr, act_scan_ev, act_aug_fw, act_push;
	assign act_clr     = (cmd.act == imf_pkg::A_CLR);
	assign act_scan_ev = (cmd.act == imf_pkg::A_SCAN_EV);
	assign act_aug_fw  = (cmd.act == imf_pkg::A_AUG_FW);
	assign act_push    = (cmd.act == imf_pkg::A_PUSH);

	// RAM signals
	logic          cap_we;
	logic [AW-1:0] cap_waddr, cap_raddr;
	logic [CW-1:0] cap_wdata, cap_rd;
	logic          flw_we;
	logic [AW-1:0] flw_waddr, flwt_waddr, flw_raddr;
	logic [CW-1:0] flw_wdata, flw_rd, flwt_rd;
	logic          q_we;
	logic [NW-1:0] q_waddr, q_wdata, q_rd;
	logic          lab_we;
	logic [NW-1:0] lab_waddr;
	logic [CW-1:0] lab_wdata, lab_rd;
	logic          par_we;
	logic [CW-1:0] par_wdata, par_rd;

	// Scan evaluation
	logic          fwd, rev, hit;
	logic [CW-1:0] amount, minv, new_flow;
	logic [NW-1:0] par_u;
	logic [CW-1:0] limit_eff;

	assign fwd       = flw_rd < cap_rd;
	assign rev       = flwt_rd != '0;
	assign hit       = act_scan_ev && !visited_q[v_q] && (fwd || rev);
	assign amount    = fwd ? CW'(cap_rd - flw_rd) : flwt_rd;
	assign minv      = (amount < lab_u_q) ? amount : lab_u_q;
	assign new_flow  = rev_q ? CW'(flw_rd - d_q) : CW'(flw_rd + d_q);
	assign par_u     = par_rd[NW-1:0];
	assign limit_eff = (limit_q == '0) ? CW'(1) : limit_q;

	assign cap_we    = act_clr || (cmd.act == imf_pkg::A_SET);
	assign cap_waddr = act_clr ? clr_cnt_q : {from_q, to_q};
	assign cap_wdata = act_clr ? '0 : capin_q;
	assign cap_raddr = (cmd.act == imf_pkg::A_SUM_RD) ? {src_q, v_q} : {u_q, v_q};

	assign flw_we     = act_clr || act_aug_fw;
	assign flw_waddr  = act_clr ? clr_cnt_q : aug_addr_q;
	assign flwt_waddr = act_clr ? clr_cnt_q : {aug_addr_q[NW-1:0], aug_addr_q[AW-1:NW]};
	assign flw_wdata  = act_clr ? '0 : new_flow;

	always_comb begin
		priority case (cmd.act)
			imf_pkg::A_RDREQ:  flw_raddr = {from_q, to_q};
			imf_pkg::A_SUM_RD: flw_raddr = {src_q, v_q};
			imf_pkg::A_AUG_PW: flw_raddr = par_rd[CW-1] ? {cur_q, par_u} : {par_u, cur_q};
			default:           flw_raddr = {u_q, v_q};
		endcase
	end

	assign q_we    = (cmd.act == imf_pkg::A_INIT) ||
	                 (hit && (v_q != snk_q) && !tail_q[PW-1]);
	assign q_waddr = (cmd.act == imf_pkg::A_INIT) ? '0 : tail_q[NW-1:0];
	assign q_wdata = (cmd.act == imf_pkg::A_INIT) ? src_q : v_q;

	assign lab_we    = (cmd.act == imf_pkg::A_INIT) || hit;
	assign lab_waddr = (cmd.act == imf_pkg::A_INIT) ? src_q : v_q;
	assign lab_wdata = (cmd.act == imf_pkg::A_INIT) ? limit_eff : minv;

	assign par_we    = hit;
	assign par_wdata = {!fwd, {(CW-NW-1){1'b0}}, u_q};

	imf_ram #(.WIDTH(CW), .DEPTH(imf_pkg::CELLS)) u_cap (
		.clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
		.raddr(cap_raddr), .rdata(cap_rd)
	);

	imf_ram #(.WIDTH(CW), .DEPTH(imf_pkg::CELLS)) u_flow (
		.clk(clk), .we(flw_we), .waddr(flw_waddr), .wdata(flw_wdata),
		.raddr(flw_raddr), .rdata(flw_rd)
	);

	// Transposed copy of the flow store so reverse arcs read in the same cycle.
	imf_ram #(.WIDTH(CW), .DEPTH(imf_pkg::CELLS)) u_flow_t (
		.clk(clk), .we(flw_we), .waddr(flwt_waddr), .wdata(flw_wdata),
		.raddr({u_q, v_q}), .rdata(flwt_rd)
	);

	imf_ram #(.WIDTH(NW), .DEPTH(imf_pkg::NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q[NW-1:0]), .rdata(q_rd)
	);

	imf_ram #(.WIDTH(CW), .DEPTH(imf_pkg::NODES)) u_label (
		.clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
		.raddr(q_rd), .rdata(lab_rd)
	);

	imf_ram #(.WIDTH(CW), .DEPTH(imf_pkg::NODES)) u_parent (
		.clk(clk), .we(par_we), .waddr(v_q), .wdata(par_wdata),
		.raddr(cur_q), .rdata(par_rd)
	);

	// Handshakes
	assign s_axis_tready = (cmd.act == imf_pkg::A_ACCEPT);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {{(16-VW){1'b0}}, out_val_q};

	assign sts.in_fire    = s_axis_tvalid && s_axis_tready;
	assign sts.in_op      = s_axis_tuser;
	assign sts.src_eq_snk = (src_q == snk_q);
	assign sts.q_nonempty = (head_q < tail_q);
	assign sts.v_last     = (v_q == imf_pkg::NODE_LAST);
	assign sts.sink_hit   = hit && (v_q == snk_q);
	assign sts.cur_is_src = (cur_q == src_q);
	assign sts.clr_last   = &clr_cnt_q;
	assign sts.out_free   = !out_valid_q || m_axis_tready;

	// Configuration and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q       <= '0;
			snk_q       <= imf_pkg::NODE_LAST;
			limit_q     <= imf_pkg::LIMIT_RST;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			visited_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
		end else begin
			if (cfg_valid) begin
				priority case (cfg_index)
					imf_pkg::REG_SOURCE: src_q   <= cfg_data[NW-1:0];
					imf_pkg::REG_SINK:   snk_q   <= cfg_data[NW-1:0];
					imf_pkg::REG_LIMIT:  limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (act_clr) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (act_push && sts.out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.act == imf_pkg::A_INIT) begin
				// Only the source is marked visited at the start of a search.
				visited_q <= {{(imf_pkg::NODES-1){1'b0}}, 1'b1} << src_q;
				head_q    <= '0;
				tail_q    <= PW'(1);
			end else begin
				if (hit) visited_q[v_q] <= 1'b1;
				if (q_we) tail_q <= tail_q + PW'(1);
				if (cmd.act == imf_pkg::A_DEQ_W) head_q <= head_q + PW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (sts.in_fire) begin
			from_q  <= s_axis_tdata[NW-1:0];
			to_q    <= s_axis_tdata[2*NW-1:NW];
			capin_q <= s_axis_tdata[2*NW+CW-1:2*NW];
		end
		if (act_push && sts.out_free) begin
			out_kind_q <= res_kind_q;
			out_val_q  <= res_val_q;
		end
		unique case (cmd.act)
			imf_pkg::A_SET, imf_pkg::A_NULL: begin
				res_kind_q <= imf_pkg::KIND_ACK;
				res_val_q  <= '0;
			end
			imf_pkg::A_RD_W: begin
				res_kind_q <= imf_pkg::KIND_FLOW;
				res_val_q  <= VW'(flw_rd);
			end
			imf_pkg::A_DEQ_W: begin
				u_q <= q_rd;
			end
			imf_pkg::A_LAB_W: begin
				lab_u_q <= lab_rd;
				v_q     <= '0;
			end
			imf_pkg::A_SCAN_EV: begin
				v_q <= v_q + NW'(1);
				if (hit) d_q <= minv;
			end
			imf_pkg::A_AUG_ST: begin
				cur_q <= snk_q;
			end
			imf_pkg::A_AUG_PW: begin
				pu_q       <= par_u;
				rev_q      <= par_rd[CW-1];
				aug_addr_q <= flw_raddr;
			end
			imf_pkg::A_AUG_FW: begin
				cur_q <= pu_q;
			end
			imf_pkg::A_SUM_ST: begin
				res_kind_q <= imf_pkg::KIND_TOTAL;
				res_val_q  <= '0;
				v_q        <= '0;
			end
			imf_pkg::A_SUM_EV: begin
				v_q <= v_q + NW'(1);
				if (cap_rd != '0) res_val_q <= res_val_q + VW'(flw_rd);
			end
			default: ;
		endcase
	end

endmodule
